FILE: hdl/vector_distance_unit_defines.svh
// Assertion macros shared by the block's modules.
`ifndef VECTOR_DISTANCE_UNIT_DEFINES_SVH
`define VECTOR_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VDU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define VDU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/vdu_pkg.sv
`default_nettype none
package vdu_pkg;

  localparam int ELEM_BITS = 16;
  localparam int MAX_LEN   = 4096;
  localparam int LEN_W     = $clog2(MAX_LEN) + 1;
  localparam int DIFF_W    = ELEM_BITS + 1;
  localparam int PROD_W    = 2 * ELEM_BITS;
  localparam int SQP_W     = 2 * DIFF_W;
  localparam int SQ_W      = 2 * ELEM_BITS + LEN_W - 1;
  localparam int ABS_W     = ELEM_BITS + LEN_W;
  localparam int DOT_W     = 2 * ELEM_BITS + LEN_W;
  localparam int NORM_W    = 2 * ELEM_BITS + LEN_W - 2;
  localparam int VAL_W     = 32;
  localparam int ROOT_W    = 32;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int QUO_W     = 31;
  localparam int NORM_SH   = 20;
  localparam int MAG_SH    = 19;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [1:0] MODE_EUCLID    = 2'd0;
  localparam logic [1:0] MODE_MANHATTAN = 2'd1;
  localparam logic [1:0] MODE_CHEBYSHEV = 2'd2;
  localparam logic [1:0] MODE_COSINE    = 2'd3;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] elem_a;
    logic signed [ELEM_BITS-1:0] elem_b;
    logic                        last_pair;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] distance_value;
    logic                    zero_norm;
    logic                    length_overflow;
  } out_t;

  // Finished vector totals handed from front to back.
  typedef struct packed {
    logic [1:0]              mode;
    logic [SQ_W-1:0]         sq_sum;
    logic [ABS_W-1:0]        abs_sum;
    logic [DIFF_W-1:0]       max_diff;
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
    logic                    ovf;
  } job_t;

endpackage
`default_nettype wire

FILE: hdl/vector_distance_unit.sv
// Channel  | Dir | Handshake            | Payload
// input    | in  | push / full          | in_item: elem_a, elem_b, last_pair
// result   | out | pop / empty          | out_item: distance_value, zero_norm,
//          |     |                      |           length_overflow
// config   | in  | cfg_valid/cfg_ready  | cfg_data: metric_mode
//
// The front end takes one element pair per cycle while full is low (multiply
// stage, then accumulate stage). The back end runs per vector: manhattan/
// chebyshev pass a total straight through, euclidean takes one root digit a
// cycle, cosine up to two 32-step roots, one multiply, a 31-step divide; a
// two-entry job queue lets it overlap the next vector.
// full rises while the job queue plus a pending last pair fill it.
// rst is synchronous, active high; clears control, metric_mode to euclidean.
`default_nettype none
module vector_distance_unit import vdu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire in_t        in_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_data,
  output logic            empty,
  input  wire logic       pop,
  output out_t            out_item
);

  logic [1:0]        metric_mode;
  logic              pend_last;
  logic              res_valid;
  logic [QCNT_W-1:0] q_count;
  logic              job_push;
  logic              job_pop;
  logic              q_empty;
  job_t              job_w, job_r;

  // config always taken; the mode is read as a finished vector enters the queue
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_EUCLID;
    end else if (cfg_valid) begin
      metric_mode <= cfg_data;
    end
  end

  // reserve queue room for a last pair still in the multiply stage
  assign full     = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(pend_last)) >= (QCNT_W+1)'(QDEPTH);
  assign q_empty  = (q_count == '0);

  vdu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (push & ~full),
    .item      (in_item),
    .mode      (metric_mode),
    .pend_last (pend_last),
    .job_push  (job_push),
    .job       (job_w)
  );

  vdu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_w),
    .pop   (job_pop),
    .rdata (job_r),
    .count (q_count)
  );

  vdu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_in    (job_r),
    .job_avail (~q_empty),
    .job_pop   (job_pop),
    .res_pop   (pop & res_valid),
    .res_valid (res_valid),
    .res       (out_item)
  );

  assign empty = ~res_valid;

endmodule
`default_nettype wire

FILE: hdl/vdu_front.sv
`default_nettype none
`include "vector_distance_unit_defines.svh"
module vdu_front import vdu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire in_t        item,
  input  wire logic [1:0] mode,
  output logic            pend_last,
  output logic            job_push,
  output job_t            job
);

  // stage A: products and range check
  logic                     a_valid;
  logic                     a_last;
  logic                     a_keep;
  logic [DIFF_W-1:0]        a_ad;
  logic [SQP_W-1:0]         a_sq;
  logic signed [PROD_W-1:0] a_ab;
  logic [PROD_W-1:0]        a_aa;
  logic [PROD_W-1:0]        a_bb;
  logic [LEN_W-1:0]         pair_count;

  // stage B: running totals
  logic [SQ_W-1:0]         sq_sum, sq_sum_next;
  logic [ABS_W-1:0]        abs_sum, abs_sum_next;
  logic [DIFF_W-1:0]       max_diff, max_diff_next;
  logic signed [DOT_W-1:0] dot, dot_next;
  logic [NORM_W-1:0]       norm_a, norm_a_next;
  logic [NORM_W-1:0]       norm_b, norm_b_next;
  logic                    ovf, ovf_next;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        adiff;
  logic                     in_range;

  assign diff     = DIFF_W'(item.elem_a) - DIFF_W'(item.elem_b);
  assign adiff    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign in_range = (pair_count < LEN_W'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      a_last     <= 1'b0;
      a_keep     <= 1'b0;
      pair_count <= '0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        a_last <= item.last_pair;
        a_keep <= in_range;
        if (item.last_pair) begin
          pair_count <= '0;
        end else if (in_range) begin
          pair_count <= pair_count + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ad <= adiff;
      a_sq <= adiff * adiff;
      a_ab <= item.elem_a * item.elem_b;
      a_aa <= PROD_W'(item.elem_a) * PROD_W'(item.elem_a);
      a_bb <= PROD_W'(item.elem_b) * PROD_W'(item.elem_b);
    end
  end

  always_comb begin
    sq_sum_next   = sq_sum;
    abs_sum_next  = abs_sum;
    max_diff_next = max_diff;
    dot_next      = dot;
    norm_a_next   = norm_a;
    norm_b_next   = norm_b;
    ovf_next      = ovf;
    if (a_valid) begin
      if (a_keep) begin
        sq_sum_next  = sq_sum + SQ_W'(a_sq);
        abs_sum_next = abs_sum + ABS_W'(a_ad);
        if (a_ad > max_diff) begin
          max_diff_next = a_ad;
        end
        dot_next    = dot + DOT_W'(a_ab);
        norm_a_next = norm_a + NORM_W'(a_aa);
        norm_b_next = norm_b + NORM_W'(a_bb);
      end else begin
        ovf_next = 1'b1;
      end
    end
  end

  assign job_push  = a_valid & a_last;
  assign pend_last = a_valid & a_last;

  always_comb begin
    job.mode     = mode;
    job.sq_sum   = sq_sum_next;
    job.abs_sum  = abs_sum_next;
    job.max_diff = max_diff_next;
    job.dot      = dot_next;
    job.norm_a   = norm_a_next;
    job.norm_b   = norm_b_next;
    job.ovf      = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst || job_push) begin
      sq_sum   <= '0;
      abs_sum  <= '0;
      max_diff <= '0;
      dot      <= '0;
      norm_a   <= '0;
      norm_b   <= '0;
      ovf      <= 1'b0;
    end else begin
      sq_sum   <= sq_sum_next;
      abs_sum  <= abs_sum_next;
      max_diff <= max_diff_next;
      dot      <= dot_next;
      norm_a   <= norm_a_next;
      norm_b   <= norm_b_next;
      ovf      <= ovf_next;
    end
  end

  `VDU_ASSERT_NOW(a_count_bound, 1'b1, pair_count <= LEN_W'(MAX_LEN), "pair count past limit")

endmodule
`default_nettype wire

FILE: hdl/vdu_queue.sv
`default_nettype none
`include "vector_distance_unit_defines.svh"
module vdu_queue import vdu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire job_t  wdata,
  input  wire logic  pop,
  output job_t       rdata,
  output logic [QCNT_W-1:0] count
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;

  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  `VDU_ASSERT_NOW(q_no_overrun, push && !pop, count < QCNT_W'(QDEPTH), "queue overrun")
  `VDU_ASSERT_NOW(q_no_underrun, pop, count != '0, "queue underrun")

endmodule
`default_nettype wire

FILE: hdl/vdu_back.sv
`default_nettype none
`include "vector_distance_unit_defines.svh"
module vdu_back import vdu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire job_t  job_in,
  input  wire logic  job_avail,
  output logic       job_pop,
  input  wire logic  res_pop,
  output logic       res_valid,
  output out_t       res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQRT_E = 3'd1;
  localparam logic [2:0] S_SQRT_A = 3'd2;
  localparam logic [2:0] S_SQRT_B = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_DIVI   = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]          state;
  job_t                job;
  logic [4:0]          cnt;
  logic [RAD_W-1:0]    sq_x, sq_r, sq_bit;
  logic [ROOT_W-1:0]   root_a, root_b;
  logic [RAD_W-1:0]    prod;
  logic [RAD_W:0]      rem;
  logic [QUO_W-1:0]    quo;
  logic [VAL_W-1:0]    val;
  logic                zn;

  // one root digit per cycle
  logic [RAD_W-1:0] sq_t, sq_x_n, sq_r_n;
  logic             sq_ge;
  assign sq_t   = sq_r + sq_bit;
  assign sq_ge  = (sq_x >= sq_t);
  assign sq_x_n = sq_ge ? sq_x - sq_t : sq_x;
  assign sq_r_n = sq_ge ? (sq_r >> 1) + sq_bit : sq_r >> 1;

  // one quotient bit per cycle
  logic [RAD_W:0]   rem_sh;
  logic             div_ge;
  logic [QUO_W-1:0] quo_n;
  assign rem_sh = {rem[RAD_W-1:0], 1'b0};
  assign div_ge = (rem_sh >= {1'b0, prod});
  assign quo_n  = {quo[QUO_W-2:0], div_ge};

  logic              neg;
  logic [DOT_W-1:0]  mag;
  logic [RAD_W-1:0]  rem0;
  assign neg  = job.dot[DOT_W-1];
  assign mag  = neg ? DOT_W'(-job.dot) : DOT_W'(job.dot);
  assign rem0 = RAD_W'({mag, MAG_SH'(0)});

  localparam logic [QUO_W-1:0] Q_ONE = QUO_W'(1) << 30;

  function automatic logic [VAL_W-1:0] signed_q(input logic n, input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0] c;
    c = (q > Q_ONE) ? Q_ONE : q;
    return n ? VAL_W'(0) - VAL_W'(c) : VAL_W'(c);
  endfunction

  logic out_free;
  assign out_free = !res_valid || res_pop;
  assign job_pop  = (state == S_IDLE) && job_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // in S_DONE a popped result is replaced by the new one below
      if (res_pop && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_avail) begin
            job    <= job_in;
            zn     <= 1'b0;
            sq_r   <= '0;
            sq_bit <= RAD_W'(1) << (RAD_W - 2);
            cnt    <= 5'd31;
            unique case (job_in.mode)
              MODE_EUCLID: begin
                sq_x  <= RAD_W'(job_in.sq_sum);
                state <= S_SQRT_E;
              end
              MODE_MANHATTAN: begin
                val   <= VAL_W'(job_in.abs_sum);
                state <= S_DONE;
              end
              MODE_CHEBYSHEV: begin
                val   <= VAL_W'(job_in.max_diff);
                state <= S_DONE;
              end
              default: begin
                if (job_in.norm_a == '0 || job_in.norm_b == '0) begin
                  val   <= '0;
                  zn    <= 1'b1;
                  state <= S_DONE;
                end else begin
                  sq_x  <= RAD_W'({job_in.norm_a, NORM_SH'(0)});
                  state <= S_SQRT_A;
                end
              end
            endcase
          end
        end
        S_SQRT_E, S_SQRT_A, S_SQRT_B: begin
          if (cnt != 5'd0) begin
            sq_x   <= sq_x_n;
            sq_r   <= sq_r_n;
            sq_bit <= sq_bit >> 2;
            cnt    <= cnt - 5'd1;
          end else begin
            sq_r   <= '0;
            sq_bit <= RAD_W'(1) << (RAD_W - 2);
            cnt    <= 5'd31;
            if (state == S_SQRT_E) begin
              val   <= VAL_W'(sq_r_n);
              state <= S_DONE;
            end else if (state == S_SQRT_A) begin
              root_a <= ROOT_W'(sq_r_n);
              sq_x   <= RAD_W'({job.norm_b, NORM_SH'(0)});
              state  <= S_SQRT_B;
            end else begin
              root_b <= ROOT_W'(sq_r_n);
              state  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= root_a * root_b;
          state <= S_DIVI;
        end
        S_DIVI: begin
          rem <= {1'b0, rem0};
          quo <= '0;
          cnt <= 5'(QUO_W - 1);
          if (rem0 >= prod) begin
            val   <= signed_q(neg, Q_ONE);
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= div_ge ? rem_sh - {1'b0, prod} : rem_sh;
          quo <= quo_n;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            val   <= signed_q(neg, quo_n);
            state <= S_DONE;
          end
        end
        default: begin
          if (out_free) begin
            res_valid               <= 1'b1;
            res.distance_value      <= val;
            res.zero_norm           <= zn;
            res.length_overflow     <= job.ovf;
            state                   <= S_IDLE;
          end
        end
      endcase
    end
  end

  `VDU_ASSERT_NOW(b_pop_idle, job_pop, state == S_IDLE, "job taken while busy")
  `VDU_ASSERT_NOW(b_zero_val, res_valid && res.zero_norm, res.distance_value == '0,
                  "zero norm with nonzero value")

endmodule
`default_nettype wire
